// ===== rtl/lasm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_pkg
// shared widths, register indexes and traceback codes of the local alignment
// score matrix
// ----------------------------------------------------------------------------
package lasm_pkg;

    localparam int MAX_SIZE_DEFAULT = 1024;

    localparam int SIM_W   = 16;
    localparam int GAP_W   = 15;
    localparam int SIZE_W  = 11;
    localparam int SCORE_W = 32;
    localparam int POS_W   = 10;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_GAP       = 2'd1,
        REG_REVERSE   = 2'd2,
        REG_SIZE      = 2'd3
    } t_reg_idx;

    // traceback direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_DIAG = 2'd1,
        DIR_LEFT = 2'd2,
        DIR_UP   = 2'd3
    } t_dir;

endpackage

// ===== rtl/lasm_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_stream_if
// valid/ready channels: similarity cells in, scored cells out
// ----------------------------------------------------------------------------
interface lasm_cell_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lasm_pkg::SIM_W-1:0]      similarity;

    modport source (output valid, output similarity, input ready);
    modport sink   (input valid, input similarity, output ready);
endinterface

interface lasm_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lasm_pkg::SCORE_W-1:0]    score;
    lasm_pkg::t_dir                         direction;
    logic [lasm_pkg::POS_W-1:0]             row_index;
    logic [lasm_pkg::POS_W-1:0]             column_index;
    logic                                   last_cell;

    modport source (output valid, output score, output direction, output row_index,
                    output column_index, output last_cell, input ready);
    modport sink   (input valid, input score, input direction, input row_index,
                    input column_index, input last_cell, output ready);
endinterface

// ===== rtl/local_alignment_score_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_alignment_score_matrix
// smith-waterman style scoring pass over a row-major similarity matrix, with
// a row buffer of the previous row's scores
// ----------------------------------------------------------------------------
//
//  channel    | direction | beat
//  -----------+-----------+-----------------------------------------------
//  i_cell     | in        | similarity, one cell, row-major
//  o_result   | out       | score, direction, row_index, column_index,
//             |           | last_cell
//  apb        | in/out    | 4 registers at byte addresses 0, 4, 8, 12
//
//  one beat in and one beat out per cycle when neither side stalls
//  path: row buffer read and scoring stage loaded at accept, the cell scored
//  from the scoring stage, then the result register loaded as it advances
//  the row buffer takes one read and one write per cycle; a same-column
//  write is bypassed into the next read
//  synchronous active-low reset clears counters, valids, configuration and
//  neighbor registers; the row buffer holds no reset, its row-zero reads go unused
//  a stalled output holds the result register and the scoring stage; input
//  ready drops only when both are full
// ----------------------------------------------------------------------------
module local_alignment_score_matrix #(
    parameter int MAX_SIZE = lasm_pkg::MAX_SIZE_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lasm_cell_if.sink                       i_cell,
    lasm_result_if.source                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lasm_pkg::ADDR_W-1:0]     paddr,
    input  logic [lasm_pkg::DATA_W-1:0]     pwdata,
    output logic [lasm_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int CW = $clog2(MAX_SIZE);       // column / row counter width
    localparam int NW = $clog2(MAX_SIZE + 1);   // width that holds n itself
    localparam int SW = lasm_pkg::SCORE_W;
    localparam int XW = SW + 2;                 // exact sum before saturation

    localparam logic signed [XW-1:0] SAT_HI = XW'(64'sd2147483647);
    localparam logic signed [XW-1:0] SAT_LO = XW'(-64'sd2147483648);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [lasm_pkg::SIM_W-1:0]  r_threshold;
    logic [lasm_pkg::GAP_W-1:0]         r_gap;
    logic                               r_reverse;
    logic [lasm_pkg::SIZE_W-1:0]        r_matrix_size;

    logic                 w_cfg_wr;
    lasm_pkg::t_reg_idx   w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = lasm_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= '0;
            r_gap         <= '0;
            r_reverse     <= 1'b0;
            r_matrix_size <= lasm_pkg::SIZE_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                lasm_pkg::REG_THRESHOLD: r_threshold   <= pwdata[lasm_pkg::SIM_W-1:0];
                lasm_pkg::REG_GAP:       r_gap         <= pwdata[lasm_pkg::GAP_W-1:0];
                lasm_pkg::REG_REVERSE:   r_reverse     <= pwdata[0];
                lasm_pkg::REG_SIZE:      r_matrix_size <= pwdata[lasm_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback, signed threshold comes back sign-extended
    always_comb begin
        unique case (w_reg_idx)
            lasm_pkg::REG_THRESHOLD: prdata = lasm_pkg::DATA_W'(r_threshold);
            lasm_pkg::REG_GAP:       prdata = lasm_pkg::DATA_W'(r_gap);
            lasm_pkg::REG_REVERSE:   prdata = lasm_pkg::DATA_W'(r_reverse);
            lasm_pkg::REG_SIZE:      prdata = lasm_pkg::DATA_W'(r_matrix_size);
            default:                 prdata = '0;
        endcase
    end

    // matrix size in use: zero counts as one, clamp to the buffer depth
    logic [NW-1:0] w_n;
    logic [NW-1:0] w_n_m1;

    always_comb begin
        if (r_matrix_size == '0) begin
            w_n = NW'(1);
        end else if (32'(r_matrix_size) > MAX_SIZE) begin
            w_n = NW'(MAX_SIZE);
        end else begin
            w_n = NW'(r_matrix_size);
        end
    end
    assign w_n_m1 = w_n - NW'(1);

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s1_adv;     // scoring stage moves into the result register
    logic w_in_acc;     // input beat taken

    assign w_s1_adv       = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_cell.ready   = !r_s1_valid || w_s1_adv;
    assign w_in_acc       = i_cell.valid && i_cell.ready;

    // ------------------------------------------------------------------
    // position counters, advanced per accepted beat
    // ------------------------------------------------------------------
    logic [CW-1:0] r_row_cnt;
    logic [CW-1:0] r_col_cnt;
    logic          w_row_end;
    logic          w_last;

    assign w_row_end = NW'(r_col_cnt) >= w_n_m1;
    assign w_last    = w_row_end && (NW'(r_row_cnt) >= w_n_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (w_in_acc) begin
            if (w_row_end) begin
                r_col_cnt <= '0;
                r_row_cnt <= w_last ? '0 : r_row_cnt + CW'(1);
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // scoring stage registers
    // ------------------------------------------------------------------
    logic signed [lasm_pkg::SIM_W-1:0] r_s1_sim;
    logic [CW-1:0]                     r_s1_row;
    logic [CW-1:0]                     r_s1_col;
    logic                              r_s1_row_end;
    logic                              r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_sim     <= i_cell.similarity;
            r_s1_row     <= r_row_cnt;
            r_s1_col     <= r_col_cnt;
            r_s1_row_end <= w_row_end;
            r_s1_last    <= w_last;
        end
    end

    // ------------------------------------------------------------------
    // row buffer: read at accept, written when the scored cell leaves
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_row_buf [MAX_SIZE];
    logic signed [SW-1:0] r_up_mem;
    logic signed [SW-1:0] r_up_bypass;
    logic                 r_up_fwd;
    logic signed [SW-1:0] w_score;

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_row_buf[r_s1_col] <= w_score;
        end
        if (w_in_acc) begin
            r_up_mem <= r_row_buf[r_col_cnt];
        end
    end

    // same column written and read at one edge (single-column matrix)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_fwd <= 1'b0;
        end else if (w_in_acc) begin
            r_up_fwd <= w_s1_adv && (r_s1_col == r_col_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_up_bypass <= w_score;
        end
    end

    // ------------------------------------------------------------------
    // left and upper-left neighbors
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_left;
    logic signed [SW-1:0] r_upper_left;
    logic signed [SW-1:0] w_up;

    assign w_up = r_up_fwd ? r_up_bypass : r_up_mem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_upper_left <= '0;
        end else if (w_s1_adv) begin
            if (r_s1_row_end) begin
                r_left       <= '0;
                r_upper_left <= '0;
            end else begin
                r_left       <= w_score;
                r_upper_left <= w_up;
            end
        end
    end

    // ------------------------------------------------------------------
    // cell scoring
    // ------------------------------------------------------------------
    logic                  w_in_limit;
    logic                  w_matched;
    logic signed [SW-1:0]  w_best_lu;
    logic signed [SW-1:0]  w_best_ld;
    logic signed [SW-1:0]  w_pred;
    logic                  w_use_gap;
    logic signed [XW-1:0]  w_pred_x;
    logic signed [XW-1:0]  w_sim_x;
    logic signed [XW-1:0]  w_gap_x;
    logic signed [XW-1:0]  w_sum;
    logic signed [SW-1:0]  w_sum_sat;
    lasm_pkg::t_dir        w_pred_dir;
    lasm_pkg::t_dir        w_dir;

    // reverse limit n-1-row: col < n-1-row is col+row+1 < n, negative limit never passes
    always_comb begin
        if (r_reverse) begin
            w_in_limit = ((NW+1)'(r_s1_col) + (NW+1)'(r_s1_row) + (NW+1)'(1))
                         < (NW+1)'(w_n);
        end else begin
            w_in_limit = r_s1_col < r_s1_row;
        end
    end

    assign w_matched = (r_s1_sim >= r_threshold) && !r_s1_sim[lasm_pkg::SIM_W-1];

    // left and up need a strict win, ties go diagonal
    assign w_best_lu = (r_upper_left > w_up)   ? r_upper_left : w_up;
    assign w_best_ld = (r_upper_left > r_left) ? r_upper_left : r_left;

    always_comb begin
        if (r_left > w_best_lu) begin
            w_pred     = r_left;
            w_pred_dir = lasm_pkg::DIR_LEFT;
            w_use_gap  = 1'b1;
        end else if (w_up > w_best_ld) begin
            w_pred     = w_up;
            w_pred_dir = lasm_pkg::DIR_UP;
            w_use_gap  = 1'b1;
        end else begin
            w_pred     = r_upper_left;
            w_pred_dir = lasm_pkg::DIR_DIAG;
            w_use_gap  = 1'b0;
        end
    end

    assign w_pred_x = XW'(w_pred);
    assign w_sim_x  = XW'(r_s1_sim);
    assign w_gap_x  = w_use_gap ? XW'({1'b0, r_gap}) : '0;
    assign w_sum    = w_pred_x + w_sim_x - w_gap_x;

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sum_sat = SW'(SAT_HI);
        end else if (w_sum < SAT_LO) begin
            w_sum_sat = SW'(SAT_LO);
        end else begin
            w_sum_sat = w_sum[SW-1:0];
        end
    end

    always_comb begin
        if (!(w_in_limit && w_matched)) begin
            w_score = '0;
            w_dir   = lasm_pkg::DIR_NONE;
        end else if (r_s1_row == '0 || r_s1_col == '0) begin
            // edge row or column starts a fresh alignment
            w_score = SW'(r_s1_sim);
            w_dir   = lasm_pkg::DIR_DIAG;
        end else begin
            w_score = w_sum_sat;
            w_dir   = w_pred_dir;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_out_score;
    lasm_pkg::t_dir       r_out_dir;
    logic [CW-1:0]        r_out_row;
    logic [CW-1:0]        r_out_col;
    logic                 r_out_last;
    logic [31:0]          w_out_row32;
    logic [31:0]          w_out_col32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_score <= w_score;
            r_out_dir   <= w_dir;
            r_out_row   <= r_s1_row;
            r_out_col   <= r_s1_col;
            r_out_last  <= r_s1_last;
        end
    end

    // position fields are 10 bits whatever the buffer depth
    assign w_out_row32 = 32'(r_out_row);
    assign w_out_col32 = 32'(r_out_col);

    assign o_result.valid        = r_out_valid;
    assign o_result.score        = r_out_score;
    assign o_result.direction    = r_out_dir;
    assign o_result.row_index    = w_out_row32[lasm_pkg::POS_W-1:0];
    assign o_result.column_index = w_out_col32[lasm_pkg::POS_W-1:0];
    assign o_result.last_cell    = r_out_last;

endmodule
